// ----- hdl/ccs_pkg.sv -----
package ccs_pkg;

    typedef enum logic [2:0] {
        MODE_NORMAL  = 3'd0,
        MODE_SLASH   = 3'd1,
        MODE_LINE    = 3'd2,
        MODE_BLOCK   = 3'd3,
        MODE_STAR    = 3'd4,
        MODE_LIT     = 3'd5,
        MODE_LIT_ESC = 3'd6
    } scan_mode_t;

    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_STAR   = 8'h2A;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_NL     = 8'h0A;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;

    // bytes a single input item may produce
    localparam logic [1:0] RUN_NONE = 2'd0;
    localparam logic [1:0] RUN_ONE  = 2'd1;
    localparam logic [1:0] RUN_TWO  = 2'd2;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
    } in_item_t;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       byte_valid;
        logic       run_last;
        logic       text_end;
    } out_item_t;

    // everything one input item yields, queued between front and back
    typedef struct packed {
        logic [7:0] byte0;
        logic [7:0] byte1;
        logic [1:0] n_bytes;
        logic       text_last;
    } run_t;

    typedef struct packed {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

// ----- hdl/ccs_stream_if.sv -----
interface ccs_stream_if #(
    parameter type payload_t = logic
) ();
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- hdl/ccs_front.sv -----
module ccs_front (
    input  logic                   clk,
    input  logic                   rst_n,
    ccs_stream_if.sink             text_in,
    input  ccs_pkg::queue_status_t queue_status,
    output logic                   push,
    output ccs_pkg::run_t          push_run
);
    import ccs_pkg::*;

    scan_mode_t mode_reg;
    scan_mode_t mode_next;
    logic       quote_single_reg;
    logic       quote_single_next;

    logic [7:0] c;
    logic       last;
    logic [7:0] quote;
    scan_mode_t mode_scan;
    logic       quote_scan;

    logic [1:0] n_base;
    logic [7:0] b0_base;
    logic [7:0] b1_base;
    logic       tail_en;
    logic [7:0] tail_byte;

    assign c     = text_in.payload.in_byte;
    assign last  = text_in.payload.text_last;
    assign quote = quote_single_reg ? CH_SQUOTE : CH_DQUOTE;

    assign text_in.ready = !queue_status.full;
    assign push          = text_in.valid && !queue_status.full;

    // next state
    always_comb
    begin
        mode_scan  = mode_reg;
        quote_scan = quote_single_reg;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                    mode_scan = MODE_LINE;
                else if (c == CH_STAR)
                    mode_scan = MODE_BLOCK;
                else if (c == CH_DQUOTE)
                begin
                    mode_scan  = MODE_LIT;
                    quote_scan = 1'b0;
                end
                else if (c == CH_SQUOTE)
                begin
                    mode_scan  = MODE_LIT;
                    quote_scan = 1'b1;
                end
                else if (c != CH_SLASH)
                    mode_scan = MODE_NORMAL;
            end
            MODE_LINE:
            begin
                if (c == CH_NL)
                    mode_scan = MODE_NORMAL;
            end
            MODE_BLOCK:
            begin
                if (c == CH_STAR)
                    mode_scan = MODE_STAR;
            end
            MODE_STAR:
            begin
                if (c == CH_SLASH)
                    mode_scan = MODE_NORMAL;
                else if (c != CH_STAR)
                    mode_scan = MODE_BLOCK;
            end
            MODE_LIT:
            begin
                if (c == CH_BSLASH)
                    mode_scan = MODE_LIT_ESC;
                else if (c == quote)
                    mode_scan = MODE_NORMAL;
            end
            MODE_LIT_ESC:
                mode_scan = MODE_LIT;
            default:
            begin
                if (c == CH_SLASH)
                    mode_scan = MODE_SLASH;
                else if (c == CH_DQUOTE)
                begin
                    mode_scan  = MODE_LIT;
                    quote_scan = 1'b0;
                end
                else if (c == CH_SQUOTE)
                begin
                    mode_scan  = MODE_LIT;
                    quote_scan = 1'b1;
                end
                else
                    mode_scan = MODE_NORMAL;
            end
        endcase

        if (last)
        begin
            mode_next         = MODE_NORMAL;
            quote_single_next = 1'b0;
        end
        else
        begin
            mode_next         = mode_scan;
            quote_single_next = quote_scan;
        end
    end

    // emitted bytes
    always_comb
    begin
        n_base  = RUN_NONE;
        b0_base = 8'h00;
        b1_base = 8'h00;
        unique case (mode_reg)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    n_base  = RUN_TWO;
                    b0_base = CH_SPACE;
                    b1_base = CH_SPACE;
                end
                else if (c != CH_STAR)
                begin
                    b0_base = CH_SLASH;
                    b1_base = c;
                    n_base  = (c == CH_SLASH) ? RUN_ONE : RUN_TWO;
                end
            end
            MODE_LINE:
            begin
                n_base  = RUN_ONE;
                b0_base = (c == CH_NL) ? CH_NL : CH_SPACE;
            end
            MODE_BLOCK:
            begin
                if (c != CH_STAR)
                begin
                    n_base  = RUN_ONE;
                    b0_base = (c == CH_NL) ? CH_NL : CH_SPACE;
                end
            end
            MODE_STAR:
            begin
                if (c == CH_STAR)
                begin
                    n_base  = RUN_ONE;
                    b0_base = CH_SPACE;
                end
                else if (c != CH_SLASH)
                begin
                    n_base  = RUN_TWO;
                    b0_base = CH_SPACE;
                    b1_base = (c == CH_NL) ? CH_NL : CH_SPACE;
                end
            end
            MODE_LIT, MODE_LIT_ESC:
            begin
                n_base  = RUN_ONE;
                b0_base = c;
            end
            default:
            begin
                if (c != CH_SLASH)
                begin
                    n_base  = RUN_ONE;
                    b0_base = c;
                end
            end
        endcase

        // a held slash or star is flushed at end of text
        tail_en   = last && (mode_scan == MODE_SLASH || mode_scan == MODE_STAR);
        tail_byte = (mode_scan == MODE_SLASH) ? CH_SLASH : CH_SPACE;

        push_run.byte0     = b0_base;
        push_run.byte1     = b1_base;
        push_run.n_bytes   = n_base;
        push_run.text_last = last;
        if (tail_en)
        begin
            priority case (n_base)
                RUN_NONE:
                begin
                    push_run.byte0   = tail_byte;
                    push_run.n_bytes = RUN_ONE;
                end
                RUN_ONE:
                begin
                    push_run.byte1   = tail_byte;
                    push_run.n_bytes = RUN_TWO;
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg         <= MODE_NORMAL;
            quote_single_reg <= 1'b0;
        end
        else if (push)
        begin
            mode_reg         <= mode_next;
            quote_single_reg <= quote_single_next;
        end
    end

endmodule

// ----- hdl/ccs_queue.sv -----
module ccs_queue #(
    parameter int DEPTH = 4
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   push,
    input  ccs_pkg::run_t          push_run,
    input  logic                   pop,
    output ccs_pkg::run_t          head_run,
    output ccs_pkg::queue_status_t status
);
    import ccs_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

    run_t             slots_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    assign status.full  = (count_reg == FULL_CNT);
    assign status.empty = (count_reg == '0);
    assign head_run     = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slots_reg[wr_ptr_reg] <= push_run;
    end

endmodule

// ----- hdl/ccs_back.sv -----
module ccs_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  ccs_pkg::run_t          head_run,
    input  ccs_pkg::queue_status_t queue_status,
    output logic                   pop,
    ccs_stream_if.source           text_out
);
    import ccs_pkg::*;

    logic      out_valid_reg;
    logic      out_valid_next;
    out_item_t out_item_reg;
    out_item_t out_item_next;
    logic      second_reg;
    logic      second_next;
    logic      load;
    logic      take;
    logic      split;

    assign text_out.valid   = out_valid_reg;
    assign text_out.payload = out_item_reg;

    assign load  = !out_valid_reg || text_out.ready;
    assign take  = load && !queue_status.empty;
    // two-byte run, first byte still to go
    assign split = (head_run.n_bytes == RUN_TWO) && !second_reg;
    assign pop   = take && !split;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        second_next    = second_reg;
        out_item_next  = out_item_reg;
        if (load)
        begin
            out_valid_next = !queue_status.empty;
            if (take)
            begin
                out_item_next.out_byte   = second_reg ? head_run.byte1 : head_run.byte0;
                out_item_next.byte_valid = (head_run.n_bytes != RUN_NONE);
                out_item_next.run_last   = !split;
                out_item_next.text_end   = !split && head_run.text_last;
                second_next              = split;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            second_reg    <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            second_reg    <= second_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
    end

endmodule

// ----- hdl/c_comment_stripper.sv -----
// Channel    Dir  Payload                                      Handshake
// text_in    in   in_byte[7:0], text_last                      valid/ready
// text_out   out  out_byte[7:0], byte_valid, run_last, text_end valid/ready
//
// One input item is taken per cycle while the run queue has room; each item
// yields one or two result items, delivered one per cycle by the output
// register while the receiver is ready.
// Each run is held in a queue slot, then each item in the output register.
// rst_n clears the scanner state, the queue pointers and the output valid.
// Front and back stall independently: the queue absorbs output back-pressure.
module c_comment_stripper #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic         clk,
    input  logic         rst_n,
    ccs_stream_if.sink   text_in,
    ccs_stream_if.source text_out
);
    import ccs_pkg::*;

    logic          push;
    logic          pop;
    run_t          push_run;
    run_t          head_run;
    queue_status_t queue_status;

    // front: scanner state, classifies each byte into a run of 0..2 bytes
    ccs_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .text_in      (text_in),
        .queue_status (queue_status),
        .push         (push),
        .push_run     (push_run)
    );

    // short queue of runs between the two halves
    ccs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_run (push_run),
        .pop      (pop),
        .head_run (head_run),
        .status   (queue_status)
    );

    // back: splits each run into result items through the output register
    ccs_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_run     (head_run),
        .queue_status (queue_status),
        .pop          (pop),
        .text_out     (text_out)
    );

endmodule

// ----- bench/tb_c_comment_stripper.sv -----
`timescale 1ns / 100ps

module tb_c_comment_stripper;

    import ccs_pkg::*;

    // Bench timing and traffic shape
    localparam int RANDOM_ITEMS   = 700;
    localparam int IDLE_PCT       = 8;     // per cent of cycles each side idles
    localparam int HOLD_AT        = 300;   // receiver cycle at which the long hold-off starts
    localparam int HOLD_CYCLES    = 150;   // long enough to fill the run queue
    localparam int QUIET_FROM     = 520;   // window with no idling on either side
    localparam int QUIET_TO       = 720;
    localparam int DRAIN_CYCLES   = 20;    // wait after the last owed result, to catch any surplus
    localparam int STALL_LIMIT    = 2000;  // cycles with no handshake at all

    // One row of stimulus. Where typed is set, the results are written out in the row
    // and replace what the predictor gives; the predictor still tracks the scanner state.
    typedef struct packed {
        logic [7:0] in_byte;
        logic       text_last;
        logic       typed;
        logic [1:0] n_typed;
        out_item_t  typed0;
        out_item_t  typed1;
    } stim_row_t;

    localparam out_item_t NO_RES = '0;

    localparam logic [7:0] SPECIALS [7] = '{
        CH_SLASH, CH_STAR, CH_BSLASH, CH_NL, CH_SPACE, CH_DQUOTE, CH_SQUOTE
    };

    localparam int DIR_ROWS = 29;

    localparam stim_row_t DIRECTED_TAB [DIR_ROWS] = '{
        // plain bytes straight after reset, and the byte extremes
        '{"A",       1'b0, 1'b1, 2'd1, '{"A",   1'b1, 1'b1, 1'b0}, NO_RES},
        '{8'h00,     1'b0, 1'b1, 2'd1, '{8'h00, 1'b1, 1'b1, 1'b0}, NO_RES},
        '{8'hFF,     1'b1, 1'b1, 2'd1, '{8'hFF, 1'b1, 1'b1, 1'b1}, NO_RES},
        // held slash gives an empty item, then comes out ahead of the next byte
        '{CH_SLASH,  1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b0}, NO_RES},
        '{"x",       1'b0, 1'b1, 2'd2, '{CH_SLASH, 1'b1, 1'b0, 1'b0},
                                       '{"x", 1'b1, 1'b1, 1'b0}},
        // line comment: opener becomes two spaces, newline survives
        '{CH_SLASH,  1'b0, 1'b1, 2'd1, '{8'h00, 1'b0, 1'b1, 1'b0}, NO_RES},
        '{CH_SLASH,  1'b0, 1'b1, 2'd2, '{CH_SPACE, 1'b1, 1'b0, 1'b0},
                                       '{CH_SPACE, 1'b1, 1'b1, 1'b0}},
        '{CH_NL,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // block comment with a run of stars, a star before newline, then close
        '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_NL,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // string with an escaped quote and a newline inside it
        '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_BSLASH, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_NL,     1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_DQUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        // character literal left open on an escape at end of text
        '{CH_SQUOTE, 1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_BSLASH, 1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // held slash at end of text
        '{CH_SLASH,  1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // held star at end of text
        '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b1, 1'b0, 2'd0, NO_RES, NO_RES},
        // block comment never closed: last byte still yields a blank
        '{CH_SLASH,  1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{CH_STAR,   1'b0, 1'b0, 2'd0, NO_RES, NO_RES},
        '{"z",       1'b1, 1'b0, 2'd0, NO_RES, NO_RES}
    };

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    ccs_stream_if #(.payload_t(in_item_t))  text_in_if ();
    ccs_stream_if #(.payload_t(out_item_t)) text_out_if ();

    c_comment_stripper i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .text_in  (text_in_if),
        .text_out (text_out_if)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    stim_row_t  text_stim_q [$];   // every input item, directed rows first
    out_item_t  stripped_q [$];    // result items still owed by the block
    int         fail_cnt  = 0;
    int         cycle_cnt = 0;
    int         stall_cyc = 0;
    int         taken_cnt = 0;
    bit         feed_done = 1'b0;

    // Shadow of the scanner
    scan_mode_t scan_st      = MODE_NORMAL;
    logic       quote_single = 1'b0;
    logic [7:0] emit_buf [2];
    int         emit_n;

    function automatic void emit_char(input logic [7:0] b);
        if (emit_n < 2)
        begin
            emit_buf[emit_n] = b;
            emit_n++;
        end
    endfunction

    // code outside any comment or literal
    function automatic void plain_char(input logic [7:0] c);
        if (c == CH_SLASH)
            scan_st = MODE_SLASH;
        else if (c == CH_DQUOTE || c == CH_SQUOTE)
        begin
            emit_char(c);
            quote_single = (c == CH_SQUOTE);
            scan_st      = MODE_LIT;
        end
        else
        begin
            emit_char(c);
            scan_st = MODE_NORMAL;
        end
    endfunction

    // Advances the shadow scanner by one byte; returns how many result items it owes.
    function automatic int strip_byte(input logic [7:0] c, input logic last,
                                      output out_item_t res [2]);
        logic [7:0] quote;
        int         k;
        quote  = quote_single ? CH_SQUOTE : CH_DQUOTE;
        emit_n = 0;
        res[0] = '0;
        res[1] = '0;
        case (scan_st)
            MODE_SLASH:
            begin
                if (c == CH_SLASH)
                begin
                    emit_char(CH_SPACE);
                    emit_char(CH_SPACE);
                    scan_st = MODE_LINE;
                end
                else if (c == CH_STAR)
                    scan_st = MODE_BLOCK;
                else
                begin
                    emit_char(CH_SLASH);
                    plain_char(c);
                end
            end
            MODE_LINE:
            begin
                if (c == CH_NL)
                begin
                    emit_char(CH_NL);
                    scan_st = MODE_NORMAL;
                end
                else
                    emit_char(CH_SPACE);
            end
            MODE_BLOCK:
            begin
                if (c == CH_STAR)
                    scan_st = MODE_STAR;
                else
                    emit_char(c == CH_NL ? CH_NL : CH_SPACE);
            end
            MODE_STAR:
            begin
                if (c == CH_SLASH)
                    scan_st = MODE_NORMAL;
                else if (c == CH_STAR)
                    emit_char(CH_SPACE);
                else
                begin
                    // held star turns into a blank, then the byte itself
                    emit_char(CH_SPACE);
                    emit_char(c == CH_NL ? CH_NL : CH_SPACE);
                    scan_st = MODE_BLOCK;
                end
            end
            MODE_LIT:
            begin
                emit_char(c);
                if (c == CH_BSLASH)
                    scan_st = MODE_LIT_ESC;
                else if (c == quote)
                    scan_st = MODE_NORMAL;
            end
            MODE_LIT_ESC:
            begin
                emit_char(c);
                scan_st = MODE_LIT;
            end
            default:
                plain_char(c);
        endcase
        if (last)
        begin
            // flush whatever is held back, then start afresh
            if (scan_st == MODE_SLASH)
                emit_char(CH_SLASH);
            else if (scan_st == MODE_STAR)
                emit_char(CH_SPACE);
            scan_st      = MODE_NORMAL;
            quote_single = 1'b0;
        end
        if (emit_n == 0)
        begin
            res[0].run_last = 1'b1;
            res[0].text_end = last;
            return 1;
        end
        for (k = 0; k < emit_n; k++)
        begin
            res[k].out_byte   = emit_buf[k];
            res[k].byte_valid = 1'b1;
            res[k].run_last   = (k == emit_n - 1);
            res[k].text_end   = (k == emit_n - 1) && last;
        end
        return emit_n;
    endfunction

    // Random text generation
    task automatic push_byte(input logic [7:0] b);
        stim_row_t row;
        row           = '0;
        row.in_byte   = b;
        row.text_last = ($urandom_range(59) == 0);
        text_stim_q.insert(text_stim_q.size(), row);
    endtask

    function automatic logic [7:0] body_byte();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return 8'($urandom_range(8'h7A, 8'h61));
        if (r < 72)
            return CH_SPACE;
        if (r < 80)
            return CH_NL;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed pieces of C text, plus loose bytes and bare delimiters.
    task automatic add_fragment();
        int kind;
        int len;
        int k;
        kind = $urandom_range(9);
        len  = $urandom_range(6, 1);
        case (kind)
            0, 1, 2:
                for (k = 0; k < len; k++)
                    push_byte(body_byte());
            3:
            begin
                push_byte(CH_SLASH);
                push_byte(CH_SLASH);
                for (k = 0; k < len; k++)
                    push_byte(body_byte());
                push_byte(CH_NL);
            end
            4, 5:
            begin
                push_byte(CH_SLASH);
                push_byte(CH_STAR);
                for (k = 0; k < len; k++)
                    push_byte($urandom_range(3) == 0 ? CH_STAR : body_byte());
                push_byte(CH_STAR);
                push_byte(CH_SLASH);
            end
            6:
            begin
                push_byte(CH_DQUOTE);
                for (k = 0; k < len; k++)
                begin
                    if ($urandom_range(4) == 0)
                    begin
                        push_byte(CH_BSLASH);
                        push_byte(8'($urandom_range(255)));
                    end
                    else
                        push_byte(body_byte());
                end
                push_byte(CH_DQUOTE);
            end
            7:
            begin
                push_byte(CH_SQUOTE);
                if ($urandom_range(1) == 0)
                    push_byte(CH_BSLASH);
                push_byte(8'($urandom_range(255)));
                push_byte(CH_SQUOTE);
            end
            8:
                for (k = 0; k < len; k++)
                    push_byte(8'($urandom_range(255)));
            default:
                for (k = 0; k < len; k++)
                    push_byte(SPECIALS[$urandom_range(6)]);
        endcase
        // end the text on a fragment boundary now and then
        if ($urandom_range(7) == 0)
            text_stim_q[text_stim_q.size() - 1].text_last = 1'b1;
    endtask

    function automatic bit in_quiet();
        return cycle_cnt >= QUIET_FROM && cycle_cnt < QUIET_TO;
    endfunction

    // Sender: offers items at the falling edge, holds each until it is taken
    initial
    begin : feed
        int idx;
        text_in_if.valid   = 1'b0;
        text_in_if.payload = '0;
        wait (rst_n === 1'b1);
        @(negedge clk);
        idx = 0;
        while (idx < text_stim_q.size())
        begin
            if (!in_quiet() && $urandom_range(99) < IDLE_PCT)
            begin
                text_in_if.valid <= 1'b0;
                @(negedge clk);
            end
            else
            begin
                text_in_if.valid   <= 1'b1;
                text_in_if.payload <= {text_stim_q[idx].in_byte, text_stim_q[idx].text_last};
                do
                    @(posedge clk);
                while (!text_in_if.ready);
                idx++;
                @(negedge clk);
            end
        end
        text_in_if.valid <= 1'b0;
        feed_done = 1'b1;
    end

    // Receiver: random back-pressure, one long hold-off so the run queue fills up
    initial
    begin : drain
        int n;
        text_out_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        n = 0;
        forever
        begin
            @(negedge clk);
            n++;
            if (n == HOLD_AT)
            begin
                text_out_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
            end
            else if (in_quiet())
                text_out_if.ready <= 1'b1;
            else
                text_out_if.ready <= ($urandom_range(99) >= IDLE_PCT);
        end
    end

    // Monitor: predicts on every item taken, checks every result item delivered
    always @(posedge clk)
    begin : monitor
        out_item_t res [2];
        out_item_t want;
        out_item_t got;
        stim_row_t row;
        int        n;
        int        k;
        bit        moved;
        if (rst_n)
        begin
            cycle_cnt++;
            moved = 1'b0;
            if (text_in_if.valid && text_in_if.ready)
            begin
                moved = 1'b1;
                row   = text_stim_q[taken_cnt];
                taken_cnt++;
                n = strip_byte(text_in_if.payload.in_byte, text_in_if.payload.text_last, res);
                if (row.typed)
                begin
                    stripped_q.insert(stripped_q.size(), row.typed0);
                    if (row.n_typed == 2'd2)
                        stripped_q.insert(stripped_q.size(), row.typed1);
                end
                else
                    for (k = 0; k < n; k++)
                        stripped_q.insert(stripped_q.size(), res[k]);
            end
            if (text_out_if.valid && text_out_if.ready)
            begin
                moved = 1'b1;
                got   = text_out_if.payload;
                if (stripped_q.size() == 0)
                begin
                    $error("result item %h with nothing owed", got);
                    fail_cnt++;
                end
                else
                begin
                    want = stripped_q.pop_front();
                    if (got.out_byte !== want.out_byte)
                    begin
                        $error("out_byte: expected %h, got %h", want.out_byte, got.out_byte);
                        fail_cnt++;
                    end
                    if (got.byte_valid !== want.byte_valid)
                    begin
                        $error("byte_valid: expected %b, got %b",
                               want.byte_valid, got.byte_valid);
                        fail_cnt++;
                    end
                    if (got.run_last !== want.run_last)
                    begin
                        $error("run_last: expected %b, got %b", want.run_last, got.run_last);
                        fail_cnt++;
                    end
                    if (got.text_end !== want.text_end)
                    begin
                        $error("text_end: expected %b, got %b", want.text_end, got.text_end);
                        fail_cnt++;
                    end
                end
            end
            stall_cyc = moved ? 0 : stall_cyc + 1;
        end
    end

    // Watchdog: the run is stuck if nothing moves for too long
    initial
    begin : watchdog
        while (stall_cyc < STALL_LIMIT)
            @(posedge clk);
        $display("c_comment_stripper test failed");
        $finish;
    end

    initial
    begin : main
        int k;
        for (k = 0; k < DIR_ROWS; k++)
            text_stim_q.insert(text_stim_q.size(), DIRECTED_TAB[k]);
        while (text_stim_q.size() < DIR_ROWS + RANDOM_ITEMS)
            add_fragment();
        // asynchronous reset, released on a falling edge
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        while (!feed_done)
            @(negedge clk);
        while (stripped_q.size() != 0)
            @(negedge clk);
        // anything arriving now is a surplus result and fails in the monitor
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (fail_cnt == 0 && stripped_q.size() == 0)
            $display("c_comment_stripper test passed");
        else
            $display("c_comment_stripper test failed");
        $finish;
    end

endmodule
